// ===== src/sitr_pkg.sv =====
// Package for the signed integer to radix digits converter.
// Holds sizes, register indexes, reset values, the controller state type and
// the digit character lookup. Depends on nothing.
`default_nettype none

package sitr_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int IN_BITS        = 32;
   localparam int CHAR_BITS      = 8;
   localparam int DIGIT_BITS     = 4;
   localparam int BASE_BITS      = 5;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [BASE_BITS-1:0] MAX_BASE = 5'd16;
   localparam logic [BASE_BITS-1:0] MIN_BASE = 5'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_SIZE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHARS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHARS_HIGH = 2'd2;

   localparam logic [BASE_BITS-1:0]     BASE_RESET       = 5'd10;
   localparam logic [CSR_DATA_BITS-1:0] CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_BITS-1:0] CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;

   localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_FETCH,
      ST_LOAD,
      ST_HOLD
   } state_type;

   // Picks the character for one digit out of the two alphabet registers.
   function automatic logic [CHAR_BITS-1:0] digit_char(
      input logic [DIGIT_BITS-1:0]    digit,
      input logic [CSR_DATA_BITS-1:0] chars_low,
      input logic [CSR_DATA_BITS-1:0] chars_high
   );
      logic [2*CSR_DATA_BITS-1:0] alphabet;
      alphabet   = {chars_high, chars_low};
      digit_char = alphabet[digit*CHAR_BITS +: CHAR_BITS];
   endfunction

endpackage

`default_nettype wire

// ===== src/signed_integer_to_radix_digits.sv =====
// Flow: a bit-serial division for each digit, then a minus sign for a negative
// value, then each digit character through the fetch, load and hold states, plus
// stalls. Throughput: one number at a time; the next value is taken after the
// last character transfer.
// Reset (synchronous): controller idle, registers back to base 10 and "0-9a-f";
// the digit store is not cleared, since each number writes it before reading.
// Top level of the signed integer to radix text converter.
// Depends on sitr_pkg.
`default_nettype none

module signed_integer_to_radix_digits #(
   parameter int VALUE_BITS = sitr_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input stream; tdata: value[31:0].
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [sitr_pkg::IN_BITS-1:0]        req_tdata,
   // Result stream; tdata: out_char[7:0]; tlast: last_char.
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [sitr_pkg::CHAR_BITS-1:0]      rsp_tdata,
   output      logic                                rsp_tlast,
   // Register write port.
   input  wire logic                                csr_we,
   input  wire logic [sitr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [sitr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import sitr_pkg::*;

   localparam int BIT_CNT_BITS = $clog2(VALUE_BITS);
   localparam int CNT_BITS     = $clog2(VALUE_BITS + 1);
   localparam int ADDR_BITS    = $clog2(VALUE_BITS);
   localparam logic [BIT_CNT_BITS-1:0] BIT_LAST = BIT_CNT_BITS'(VALUE_BITS - 1);
   localparam logic [CNT_BITS-1:0]     CNT_MAX  = CNT_BITS'(VALUE_BITS);

   state_type state_ff, state_in;

   logic [BASE_BITS-1:0]     base_ff;
   logic [CSR_DATA_BITS-1:0] chars_low_ff, chars_high_ff;

   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   logic [DIGIT_BITS-1:0]   rem_ff, rem_in;
   logic                    nz_ff, nz_in;
   logic                    sign_ff, sign_in;
   logic [BIT_CNT_BITS-1:0] bit_ff, bit_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [CHAR_BITS-1:0]    out_ff, out_in;
   logic                    last_ff, last_in;
   logic [DIGIT_BITS-1:0]   rd_ff;

   logic [DIGIT_BITS-1:0]   digit_store [VALUE_BITS];
   logic                    store_we;
   logic [ADDR_BITS-1:0]    rd_addr;

   logic [IN_BITS+VALUE_BITS-1:0] in_ext;
   logic [VALUE_BITS-1:0]         raw;
   logic [BASE_BITS-1:0]          base_eff;
   logic [BASE_BITS-1:0]          rem_sh, rem_sub;
   logic                          q_bit;
   logic [CNT_BITS-1:0]           cnt_dec;

   assign in_ext  = {{VALUE_BITS{1'b0}}, req_tdata};
   assign raw     = in_ext[VALUE_BITS-1:0];
   assign cnt_dec = cnt_ff - CNT_BITS'(1);
   assign rd_addr = cnt_dec[ADDR_BITS-1:0];

   always_comb begin
      if (base_ff < MIN_BASE) begin
         base_eff = MIN_BASE;
      end else if (base_ff > MAX_BASE) begin
         base_eff = MAX_BASE;
      end else begin
         base_eff = base_ff;
      end
   end

   // One restoring division step: shift in the next magnitude bit and
   // subtract the radix when the partial remainder reaches it.
   assign rem_sh  = {rem_ff, mag_ff[VALUE_BITS-1]};
   assign q_bit   = (rem_sh >= base_eff);
   assign rem_sub = q_bit ? (rem_sh - base_eff) : rem_sh;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SIGN) || (state_ff == ST_HOLD);
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      nz_in    = nz_ff;
      sign_in  = sign_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      out_in   = out_ff;
      last_in  = last_ff;
      store_we = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sign_in  = raw[VALUE_BITS-1];
               mag_in   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
               rem_in   = '0;
               nz_in    = 1'b0;
               bit_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            mag_in = {mag_ff[VALUE_BITS-2:0], q_bit};
            rem_in = rem_sub[DIGIT_BITS-1:0];
            nz_in  = nz_ff | q_bit;
            bit_in = bit_ff + BIT_CNT_BITS'(1);
            if (bit_ff == BIT_LAST) begin
               // The quotient is complete: keep the remainder as a digit.
               store_we = (cnt_ff < CNT_MAX);
               if (cnt_ff < CNT_MAX) begin
                  cnt_in = cnt_ff + CNT_BITS'(1);
               end
               rem_in = '0;
               nz_in  = 1'b0;
               bit_in = '0;
               if (!(nz_ff | q_bit)) begin
                  if (sign_ff) begin
                     out_in   = MINUS_CHAR;
                     last_in  = 1'b0;
                     state_in = ST_SIGN;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_SIGN: begin
            if (rsp_tready) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            out_in   = digit_char(rd_ff, chars_low_ff, chars_high_ff);
            last_in  = (cnt_ff == CNT_BITS'(1));
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_tready) begin
               cnt_in   = cnt_dec;
               state_in = (cnt_ff == CNT_BITS'(1)) ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nz_ff    <= 1'b0;
         sign_ff  <= 1'b0;
         bit_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         nz_ff    <= nz_in;
         sign_ff  <= sign_in;
         bit_ff   <= bit_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         digit_store[cnt_ff[ADDR_BITS-1:0]] <= rem_sub[DIGIT_BITS-1:0];
      end
      rd_ff <= digit_store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= BASE_RESET;
         chars_low_ff  <= CHARS_LOW_RESET;
         chars_high_ff <= CHARS_HIGH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_SIZE:  base_ff       <= csr_wdata[BASE_BITS-1:0];
            CSR_CHARS_LOW:  chars_low_ff  <= csr_wdata;
            CSR_CHARS_HIGH: chars_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/sitr_checker.sv =====
// Port-level checks for the radix converter and the bind that attaches them.
// Depends on signed_integer_to_radix_digits.
`default_nettype none

module sitr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // A stalled character holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A new value first has to be divided, so no character follows at once.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("result shown right after input transfer");

   // No value is taken while characters of a number are still on offer.
   a_one_number: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted during output");

   // The final character ends the number and the output goes quiet.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("output continued after last character");

endmodule

bind signed_integer_to_radix_digits sitr_checker u_sitr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
